@@ rtl/chord_thread_pixel_shader_macros.svh @@
// Assertion macros for the chord thread pixel shader
`ifndef CHORD_THREAD_PIXEL_SHADER_MACROS_SVH
`define CHORD_THREAD_PIXEL_SHADER_MACROS_SVH
`ifndef ASSERT_OFF
`define CTPS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CTPS_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CTPS_ASSERT(lbl, clk, rst, prop, msg)
`define CTPS_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/ctps_pkg.sv @@
`default_nettype none
package ctps_pkg;

  localparam int AW = 49;

  typedef enum logic [3:0] {
    GEO_LOAD, GEO_DIFF, GEO_SQA, GEO_SQB, GEO_WCA, GEO_WSA,
    GEO_ROOT, GEO_FINISH, GEO_IDLE
  } geo_state_t;

  typedef enum logic [1:0] {
    CLS_CORE, CLS_RAMP, CLS_WHITE
  } shade_cls_t;

  localparam logic [1:0] REG_FIRST  = 2'd0;
  localparam logic [1:0] REG_SECOND = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;

  typedef struct packed {
    logic [12:0]        w;
    logic signed [29:0] wca;
    logic signed [29:0] wsa;
    logic signed [17:0] dc;
    logic signed [17:0] ds;
    logic [AW-1:0]      t128;
    logic [AW-1:0]      t192;
    logic [AW-1:0]      s16;
    logic               zero;
  } geo_t;

  function automatic longint shr_trunc(input longint v, input int s);
    if (v < 0) return -((-v) >>> s);
    return v >>> s;
  endfunction

  // Q1.15 sine of a 32-bit phase, odd Taylor series in Q30
  function automatic logic signed [15:0] sin_q15(input logic [31:0] phase);
    longint quad;
    longint frac;
    longint u;
    longint u2;
    longint t;
    longint v;
    quad = longint'(phase[31:30]);
    frac = longint'(phase[29:0]);
    u = (quad[0]) ? (longint'(1) <<< 30) - frac : frac;
    u2 = (u * u) >>> 30;
    t = 172272;
    t = shr_trunc(t * u2, 30) - 5026995;
    t = shr_trunc(t * u2, 30) + 85569306;
    t = shr_trunc(t * u2, 30) - 693598668;
    t = shr_trunc(t * u2, 30) + 1686629713;
    v = shr_trunc(t * u, 30);
    if (v < 0) v = 0;
    v = (v + 16384) >>> 15;
    if (v > 32767) v = 32767;
    if (quad >= 2) v = -v;
    return v[15:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/ctps_geometry.sv @@
`default_nettype none
module ctps_geometry #(
  parameter int NAIL_NUM  = 256,
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [7:0]    first_nail,
  input  wire logic [7:0]    second_nail,
  input  wire logic [12:0]   canvas_width,
  output ctps_pkg::geo_t     geo,
  output logic               busy
);

  logic signed [15:0] sin_tbl [256];
  logic signed [15:0] cos_tbl [256];

  for (genvar g = 0; g < 256; g++) begin : g_tbl
    localparam longint unsigned PH = (longint'(g % NAIL_NUM) << 32) / NAIL_NUM;
    localparam logic [31:0] PH32 = PH[31:0];
    localparam logic signed [15:0] SV = ctps_pkg::sin_q15(PH32);
    localparam logic signed [15:0] CV = ctps_pkg::sin_q15(PH32 + 32'h4000_0000);
    assign sin_tbl[g] = SV;
    assign cos_tbl[g] = CV;
  end

  ctps_pkg::geo_state_t state, state_next;
  logic signed [15:0] ca, sa, cb, sb;
  logic [12:0]        w;
  logic signed [17:0] dc, ds;
  logic [41:0]        acc, rem, res, bitv;
  logic [4:0]         cnt;
  logic signed [29:0] wca, wsa;
  logic [41:0]        trial;

  assign trial = res + bitv;

  always_comb begin
    state_next = state;
    case (state)
      ctps_pkg::GEO_LOAD:   state_next = ctps_pkg::GEO_DIFF;
      ctps_pkg::GEO_DIFF:   state_next = ctps_pkg::GEO_SQA;
      ctps_pkg::GEO_SQA:    state_next = ctps_pkg::GEO_SQB;
      ctps_pkg::GEO_SQB:    state_next = ctps_pkg::GEO_WCA;
      ctps_pkg::GEO_WCA:    state_next = ctps_pkg::GEO_WSA;
      ctps_pkg::GEO_WSA:    state_next = ctps_pkg::GEO_ROOT;
      ctps_pkg::GEO_ROOT:   if (cnt == 5'd20) state_next = ctps_pkg::GEO_FINISH;
      ctps_pkg::GEO_FINISH: state_next = ctps_pkg::GEO_IDLE;
      ctps_pkg::GEO_IDLE:   state_next = ctps_pkg::GEO_IDLE;
      default:              state_next = ctps_pkg::GEO_LOAD;
    endcase
    if (start) state_next = ctps_pkg::GEO_LOAD;
  end

  always_comb begin
    busy = (state != ctps_pkg::GEO_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctps_pkg::GEO_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ctps_pkg::GEO_LOAD: begin
        ca <= cos_tbl[first_nail];
        sa <= sin_tbl[first_nail];
        cb <= cos_tbl[second_nail];
        sb <= sin_tbl[second_nail];
        w  <= (17'(canvas_width) > 17'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : canvas_width;
      end
      ctps_pkg::GEO_DIFF: begin
        dc <= 18'(cb) - 18'(ca);
        ds <= 18'(sb) - 18'(sa);
      end
      ctps_pkg::GEO_SQA: acc <= 42'(36'(dc * dc));
      ctps_pkg::GEO_SQB: acc <= acc + 42'(36'(ds * ds));
      ctps_pkg::GEO_WCA: begin
        wca  <= signed'({1'b0, w}) * ca;
        rem  <= acc << 8;
        res  <= '0;
        bitv <= 42'd1 << 40;
        cnt  <= '0;
      end
      ctps_pkg::GEO_WSA: wsa <= signed'({1'b0, w}) * sa;
      ctps_pkg::GEO_ROOT: begin
        // one result bit per cycle
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 5'd1;
      end
      ctps_pkg::GEO_FINISH: begin
        geo.w    <= w;
        geo.wca  <= wca;
        geo.wsa  <= wsa;
        geo.dc   <= dc;
        geo.ds   <= ds;
        geo.t128 <= ctps_pkg::AW'(res) << 11;
        geo.t192 <= (ctps_pkg::AW'(res) << 11) + (ctps_pkg::AW'(res) << 10);
        geo.s16  <= ctps_pkg::AW'(res) << 4;
        geo.zero <= (res == '0);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/ctps_pipe.sv @@
`default_nettype none
module ctps_pipe (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ctps_pkg::geo_t geo,
  input  wire logic          busy,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [11:0]   pixel_x,
  input  wire logic [11:0]   pixel_y,
  input  wire logic [7:0]    background_pixel,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         thread_shade,
  output logic [7:0]         blended_pixel
);

  typedef struct packed {
    logic [ctps_pkg::AW-1:0] rem;
    logic [5:0]              q;
    ctps_pkg::shade_cls_t    cls;
    logic [7:0]              bg;
  } div_t;

  logic adv;
  logic v1, v2, v3;
  logic signed [29:0] ex1, ey1;
  logic signed [47:0] p1, p2;
  logic [ctps_pkg::AW-1:0] an3;
  logic [7:0] bg1, bg2, bg3;
  logic signed [14:0] xs, ys;
  logic signed [48:0] n_c;
  logic [11:0] ramp;
  logic [8:0]  sum;
  logic [7:0]  shade_c;

  div_t div_st [7];
  div_t div_nx [6];
  logic div_v  [7];

  // advance the whole line unless the result is held
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !busy;

  assign xs = signed'({2'b00, pixel_x, 1'b0}) - signed'({2'b00, geo.w});
  assign ys = signed'({2'b00, pixel_y, 1'b0}) - signed'({2'b00, geo.w});
  assign n_c = 49'(p1) - 49'(p2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid && in_ready;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ex1 <= signed'({xs, 15'd0}) - geo.wca;
      ey1 <= signed'({ys, 15'd0}) - geo.wsa;
      bg1 <= background_pixel;
      p1  <= ex1 * geo.ds;
      p2  <= ey1 * geo.dc;
      bg2 <= bg1;
      an3 <= n_c[48] ? ctps_pkg::AW'(-n_c) : ctps_pkg::AW'(n_c);
      bg3 <= bg2;
    end
  end

  // valid bits of the classify stage and the quotient stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < 7; j++) div_v[j] <= 1'b0;
    end else if (adv) begin
      div_v[0] <= v3;
      for (int j = 1; j < 7; j++) div_v[j] <= div_v[j-1];
    end
  end

  // one quotient bit per stage, most significant first
  always_comb begin
    for (int j = 0; j < 6; j++) begin
      div_nx[j] = div_st[j];
      if (div_st[j].rem >= (geo.s16 << (5 - j))) begin
        div_nx[j].rem      = div_st[j].rem - (geo.s16 << (5 - j));
        div_nx[j].q[5 - j] = 1'b1;
      end
    end
  end

  // classify against the core and white thresholds, then advance the quotient steps
  always_ff @(posedge clk) begin
    if (adv) begin
      div_st[0].rem <= an3 - geo.t128;
      div_st[0].q   <= '0;
      div_st[0].bg  <= bg3;
      if (geo.zero || an3 >= geo.t192) begin
        div_st[0].cls <= ctps_pkg::CLS_WHITE;
      end else if (an3 < geo.t128) begin
        div_st[0].cls <= ctps_pkg::CLS_CORE;
      end else begin
        div_st[0].cls <= ctps_pkg::CLS_RAMP;
      end
      for (int j = 0; j < 6; j++) div_st[j+1] <= div_nx[j];
    end
  end

  assign ramp = 12'(div_st[6].q) * 12'd55;

  always_comb begin
    case (div_st[6].cls)
      ctps_pkg::CLS_CORE:  shade_c = 8'd200;
      ctps_pkg::CLS_RAMP:  shade_c = 8'd200 + 8'(ramp >> 6);
      ctps_pkg::CLS_WHITE: shade_c = 8'd255;
      default:             shade_c = 8'd255;
    endcase
  end

  assign sum = 9'(div_st[6].bg) + 9'(shade_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= div_v[6];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      thread_shade  <= shade_c;
      blended_pixel <= (sum > 9'd255) ? 8'(sum - 9'd255) : 8'd0;
    end
  end

endmodule
`default_nettype wire

@@ rtl/chord_thread_pixel_shader.sv @@
// One request per cycle is taken while no result is held and no geometry pass runs.
// The per-pixel line is eleven register stages: offsets, products, magnitude, classify,
// six restoring quotient steps and the output register; a held result stalls every stage.
// Reset and every register write start a geometry pass (table lookup, squares,
// bit-serial square root, one bit per cycle); requests are refused during that pass.
// Reset is synchronous, active high, and loads nails 0 and 1 and a width of 512.
`default_nettype none
`include "chord_thread_pixel_shader_macros.svh"
module chord_thread_pixel_shader #(
  parameter int NAIL_NUM  = 256,
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [11:0] pixel_x,
  input  wire logic [11:0] pixel_y,
  input  wire logic [7:0]  background_pixel,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       thread_shade,
  output logic [7:0]       blended_pixel
);

  logic [7:0]  first_nail;
  logic [7:0]  second_nail;
  logic [12:0] canvas_width;
  logic        wr;
  logic        busy;
  ctps_pkg::geo_t geo;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  // register file; a write to an address beyond the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      first_nail   <= 8'd0;
      second_nail  <= 8'd1;
      canvas_width <= 13'd512;
    end else if (wr) begin
      case (paddr[3:2])
        ctps_pkg::REG_FIRST:  first_nail   <= pwdata[7:0];
        ctps_pkg::REG_SECOND: second_nail  <= pwdata[7:0];
        ctps_pkg::REG_WIDTH:  canvas_width <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      ctps_pkg::REG_FIRST:  prdata = 32'(first_nail);
      ctps_pkg::REG_SECOND: prdata = 32'(second_nail);
      ctps_pkg::REG_WIDTH:  prdata = 32'(canvas_width);
      default:              prdata = 32'd0;
    endcase
  end

  // geometry of the chord, rebuilt after reset and after every write
  ctps_geometry #(
    .NAIL_NUM  (NAIL_NUM),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_geometry (
    .clk          (clk),
    .rst          (rst),
    .start        (wr),
    .first_nail   (first_nail),
    .second_nail  (second_nail),
    .canvas_width (canvas_width),
    .geo          (geo),
    .busy         (busy)
  );

  // per-pixel distance and shade line
  ctps_pipe u_pipe (
    .clk              (clk),
    .rst              (rst),
    .geo              (geo),
    .busy             (busy),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .pixel_x          (pixel_x),
    .pixel_y          (pixel_y),
    .background_pixel (background_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .thread_shade     (thread_shade),
    .blended_pixel    (blended_pixel)
  );

  `CTPS_ASSERT(a_no_req_busy, clk, rst, in_ready |-> !busy, "request taken during geometry pass")
  `CTPS_ASSERT(a_wr_busy, clk, rst, wr |=> busy, "write did not start geometry pass")
  `CTPS_ASSERT_NR(a_rst_busy, clk, rst |=> busy, "reset did not start geometry pass")
  `CTPS_ASSERT(a_shade_floor, clk, rst, out_valid |-> thread_shade >= 8'd200, "shade below core")

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

  // index one past the last register: a write there must change nothing
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int NAILS = 256;
  localparam int WIDTH_CAP = 4096;
  localparam int QUIET_LIMIT = 4000;

  // Shade predictor and store of expected shade/blend pairs, one per request.
  class shade_scoreboard;
    int unsigned nail_a;
    int unsigned nail_b;
    int unsigned width;
    bit [7:0] shade_q[$];
    bit [7:0] blend_q[$];
    int errors;
    int matched;
    int cnt_core;
    int cnt_ramp;
    int cnt_white;

    function new();
      nail_a = 0;
      nail_b = 1;
      width = 512;
    endfunction

    function longint shift_toward_zero(longint v, int s);
      if (v < 0) return -((-v) >> s);
      return v >> s;
    endfunction

    // Q1.15 sine: odd series in Q30, Horner on u squared
    function longint sine_q15(bit [31:0] ph);
      longint u;
      longint u2;
      longint t;
      longint v;
      u = ph[30] ? (longint'(1) << 30) - longint'(ph[29:0]) : longint'(ph[29:0]);
      u2 = (u * u) >> 30;
      t = 172272;
      t = shift_toward_zero(t * u2, 30) - 5026995;
      t = shift_toward_zero(t * u2, 30) + 85569306;
      t = shift_toward_zero(t * u2, 30) - 693598668;
      t = shift_toward_zero(t * u2, 30) + 1686629713;
      v = shift_toward_zero(t * u, 30);
      if (v < 0) v = 0;
      v = (v + 16384) >> 15;
      if (v > 32767) v = 32767;
      return ph[31] ? -v : v;
    endfunction

    function longint unsigned int_root(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = longint'(1) << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function bit [31:0] phase_of(int unsigned nail);
      longint unsigned m;
      m = nail % NAILS;
      return 32'((m << 32) / NAILS);
    endfunction

    function void note(bit [11:0] px, bit [11:0] py, bit [7:0] bg);
      longint w;
      longint ca;
      longint sa;
      longint cb;
      longint sb;
      longint dc;
      longint ds;
      longint ex;
      longint ey;
      longint n;
      longint unsigned s4;
      longint unsigned d;
      int unsigned shade;
      int unsigned sum;
      bit [31:0] pa;
      bit [31:0] pb;
      w = (width > WIDTH_CAP) ? WIDTH_CAP : width;
      pa = phase_of(nail_a);
      pb = phase_of(nail_b);
      ca = sine_q15(pa + 32'h4000_0000);
      sa = sine_q15(pa);
      cb = sine_q15(pb + 32'h4000_0000);
      sb = sine_q15(pb);
      dc = cb - ca;
      ds = sb - sa;
      s4 = int_root(longint'(dc * dc + ds * ds) * 256);
      shade = 255;
      if (s4 != 0) begin
        ex = (2 * longint'(px) - w) * 32768 - w * ca;
        ey = (2 * longint'(py) - w) * 32768 - w * sa;
        n = ex * ds - ey * dc;
        if (n < 0) n = -n;
        d = longint'(n) / (s4 * 16);
        if (d > 20'hFFFFF) d = 20'hFFFFF;
        if (d < 128) shade = 200;
        else if (d < 192) shade = 200 + ((d - 128) * 55) / 64;
        else shade = 255;
      end
      if (shade == 200) cnt_core++;
      else if (shade == 255) cnt_white++;
      else cnt_ramp++;
      sum = bg + shade;
      shade_q.push_back(shade[7:0]);
      blend_q.push_back((sum > 255) ? 8'(sum - 255) : 8'd0);
    endfunction

    function void check(bit [7:0] shade, bit [7:0] blend);
      bit [7:0] es;
      bit [7:0] eb;
      if (shade_q.size() == 0) begin
        $display("%0t: result with nothing expected: shade %0d blend %0d", $time, shade, blend);
        errors++;
        return;
      end
      es = shade_q.pop_front();
      eb = blend_q.pop_front();
      if (shade !== es) begin
        $display("%0t: thread_shade expected %0d actual %0d", $time, es, shade);
        errors++;
      end
      if (blend !== eb) begin
        $display("%0t: blended_pixel expected %0d actual %0d", $time, eb, blend);
        errors++;
      end
      if (shade === es && blend === eb) matched++;
    endfunction

    function int pending();
      return shade_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic in_valid;
  logic in_ready;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [7:0] background_pixel;
  logic out_valid;
  logic out_ready;
  logic [7:0] thread_shade;
  logic [7:0] blended_pixel;

  shade_scoreboard sb = new();
  bit calm;          // no idling on either side while set
  int quiet;
  int requests;
  int settings;

  chord_thread_pixel_shader dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .background_pixel(background_pixel),
    .out_valid(out_valid), .out_ready(out_ready),
    .thread_shade(thread_shade), .blended_pixel(blended_pixel)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Random back-pressure, request recording, result check, and the no-progress watchdog.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      quiet <= 0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 22);
      if (out_valid && out_ready) sb.check(thread_shade, blended_pixel);
      if (in_valid && in_ready) sb.note(pixel_x, pixel_y, background_pixel);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("timeout: nothing moved for %0d cycles", quiet);
        $display("tb: errors");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // Drain the pipe, then write one register through a setup and an access cycle.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      ctps_pkg::REG_FIRST:  sb.nail_a = value[7:0];
      ctps_pkg::REG_SECOND: sb.nail_b = value[7:0];
      ctps_pkg::REG_WIDTH:  sb.width = value[12:0];
      default: ;
    endcase
  endtask

  task automatic set_thread(input int unsigned a, input int unsigned b, input int unsigned w);
    write_reg(ctps_pkg::REG_FIRST, a);
    write_reg(ctps_pkg::REG_SECOND, b);
    write_reg(ctps_pkg::REG_WIDTH, w);
    settings++;
  endtask

  // Hold the request until it is taken; idle beforehand at random.
  task automatic send_pixel(input int unsigned x, input int unsigned y, input int unsigned bg);
    if (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_x <= x[11:0];
    pixel_y <= y[11:0];
    background_pixel <= bg[7:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests++;
  endtask

  // Pick a point on the chord with a small offset, so core and ramp shades turn up.
  task automatic chord_pixel(input int spread);
    real w;
    real t;
    real ax;
    real ay;
    real bx;
    real by;
    int x;
    int y;
    w = (sb.width > WIDTH_CAP) ? WIDTH_CAP : sb.width;
    ax = w / 2.0 * (1.0 + $cos(2.0 * 3.14159265358979 * (sb.nail_a % NAILS) / NAILS));
    ay = w / 2.0 * (1.0 + $sin(2.0 * 3.14159265358979 * (sb.nail_a % NAILS) / NAILS));
    bx = w / 2.0 * (1.0 + $cos(2.0 * 3.14159265358979 * (sb.nail_b % NAILS) / NAILS));
    by = w / 2.0 * (1.0 + $sin(2.0 * 3.14159265358979 * (sb.nail_b % NAILS) / NAILS));
    t = $urandom_range(1000) / 1000.0;
    x = int'(ax + t * (bx - ax)) + $urandom_range(2 * spread) - spread;
    y = int'(ay + t * (by - ay)) + $urandom_range(2 * spread) - spread;
    if (x < 0) x = 0;
    if (y < 0) y = 0;
    if (x > 4095) x = 4095;
    if (y > 4095) y = 4095;
    send_pixel(x, y, $urandom_range(255));
  endtask

  task automatic random_burst(input int count);
    repeat (count) begin
      if ($urandom_range(99) < 60) chord_pixel(2);
      else send_pixel($urandom_range(4095), $urandom_range(4095), $urandom_range(255));
    end
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    pixel_x <= '0;
    pixel_y <= '0;
    background_pixel <= '0;
    calm = 1'b0;
    requests = 0;
    settings = 1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset setting: field extremes, centre, off-canvas corners.
    send_pixel(0, 0, 0);
    send_pixel(4095, 4095, 255);
    send_pixel(0, 4095, 128);
    send_pixel(4095, 0, 1);
    send_pixel(256, 256, 255);
    send_pixel(512, 0, 200);
    send_pixel(2730, 1365, 85);
    repeat (4) chord_pixel(0);

    // Diameter, then a vertical chord that the slope form would break on.
    set_thread(0, 128, 512);
    send_pixel(256, 256, 255);
    send_pixel(256, 0, 54);
    chord_pixel(1);
    set_thread(64, 192, 300);
    send_pixel(150, 10, 255);
    send_pixel(151, 290, 0);

    // Coincident nails: white whatever the pixel.
    set_thread(77, 77, 1000);
    send_pixel(500, 500, 255);
    send_pixel(0, 0, 0);

    // Canvas wider than the cap, and the narrowest widths used as given.
    set_thread(10, 200, 8191);
    send_pixel(4095, 2048, 255);
    chord_pixel(1);
    set_thread(3, 7, 1);
    send_pixel(0, 0, 100);
    set_thread(255, 0, 0);
    send_pixel(0, 0, 255);

    // A write past the last register must leave the setting alone.
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    send_pixel(1, 1, 255);

    set_thread(0, 1, 512);
    random_burst(40);
    set_thread(255, 254, 4096);
    random_burst(40);
    calm = 1'b1;
    set_thread(20, 140, 2);
    random_burst(60);
    calm = 1'b0;
    set_thread(30, 30, 700);
    random_burst(25);
    repeat (9) begin
      if ($urandom_range(3) == 0) set_thread($urandom_range(255), $urandom_range(255),
                                             $urandom_range(4097, 8191));
      else set_thread($urandom_range(255), $urandom_range(255), $urandom_range(2, 4096));
      random_burst(45);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("run: %0d requests over %0d thread settings, %0d results matched",
             requests, settings, sb.matched);
    $display("shades seen: %0d core, %0d ramp, %0d white",
             sb.cnt_core, sb.cnt_ramp, sb.cnt_white);
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
